### rtl/ccu_pkg.sv
package ccu_pkg;

  localparam int unsigned CONTIGS       = 4;
  localparam int unsigned CONTIG_LENGTH = 262144;
  localparam int unsigned COUNTER_BITS  = 16;

  localparam int unsigned CONTIG_BITS = 2;
  localparam int unsigned POS_BITS    = 18;
  localparam int unsigned PTR_BITS    = 19;
  localparam int unsigned LEN_BITS    = 20;
  localparam int unsigned ADDR_BITS   = CONTIG_BITS + POS_BITS;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = QPTR_BITS + 1;

  typedef enum logic {
    OP_APPLY = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_MATCH = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_SKIP  = 2'd2,
    KIND_OTHER = 2'd3
  } cigar_kind_e;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_READ = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_PASS = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                  kind;
    logic [ADDR_BITS-1:0]  addr;
    logic [PTR_BITS-1:0]   count;
    logic                  add;
    logic [PTR_BITS-1:0]   next_pos;
  } cmd_t;

endpackage

### rtl/ccu_front.sv
module ccu_front
  import ccu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic                   first_op_i,
  input  logic [CONTIG_BITS-1:0] contig_i,
  input  logic [POS_BITS-1:0]    position_i,
  input  logic [1:0]             cigar_kind_i,
  input  logic [LEN_BITS-1:0]    run_length_i,
  input  logic                   add_mode_i,
  input  logic                   clearing_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output cmd_t                   q_cmd_o
);

  localparam logic [PTR_BITS-1:0] LenPtr = PTR_BITS'(CONTIG_LENGTH);

  logic [PTR_BITS-1:0]    walk_ptr_q, walk_ptr_d;
  logic [CONTIG_BITS-1:0] walk_contig_q, walk_contig_d;

  logic [PTR_BITS-1:0]    ptr_base;
  logic [CONTIG_BITS-1:0] contig_base;
  logic [PTR_BITS-1:0]    room;
  logic [PTR_BITS-1:0]    count;
  logic                   is_touch;
  logic                   is_move;
  logic [PTR_BITS-1:0]    next_ptr;
  logic                   accept;

  assign in_stall_o = clearing_i || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = accept;

  always_comb begin
    ptr_base    = first_op_i ? {1'b0, position_i} : walk_ptr_q;
    contig_base = first_op_i ? contig_i : walk_contig_q;
    room        = LenPtr - ptr_base;
    count       = (run_length_i < {1'b0, room}) ? run_length_i[PTR_BITS-1:0] : room;
    is_touch    = (cigar_kind_i == KIND_MATCH) || (cigar_kind_i == KIND_DEL);
    is_move     = is_touch || (cigar_kind_i == KIND_SKIP);
    next_ptr    = is_move ? ptr_base + count : ptr_base;
  end

  always_comb begin
    walk_ptr_d    = walk_ptr_q;
    walk_contig_d = walk_contig_q;
    q_cmd_o.kind     = CMD_PASS;
    q_cmd_o.addr     = {contig_base, ptr_base[POS_BITS-1:0]};
    q_cmd_o.count    = count;
    q_cmd_o.add      = add_mode_i;
    q_cmd_o.next_pos = next_ptr;
    if (opcode_i == OP_READ) begin
      q_cmd_o.kind     = CMD_READ;
      q_cmd_o.addr     = {contig_i, position_i};
      q_cmd_o.next_pos = walk_ptr_q;
    end else begin
      if (is_touch && (count != '0)) begin
        q_cmd_o.kind = CMD_RUN;
      end
      if (accept) begin
        walk_ptr_d    = next_ptr;
        walk_contig_d = contig_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_ptr_q    <= '0;
      walk_contig_q <= '0;
    end else begin
      walk_ptr_q    <= walk_ptr_d;
      walk_contig_q <= walk_contig_d;
    end
  end

endmodule

### rtl/ccu_queue.sv
module ccu_queue
  import ccu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  cmd_t                 slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= QPTR_BITS'((32'(wr_ptr_q) + 1) % QUEUE_DEPTH);
      if (pop_i)  rd_ptr_q <= QPTR_BITS'((32'(rd_ptr_q) + 1) % QUEUE_DEPTH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_cmd_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
`endif

endmodule

### rtl/ccu_back.sv
module ccu_back
  import ccu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  cmd_t                    q_cmd_i,
  output logic                    q_pop_o,
  output logic                    clearing_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COUNTER_BITS-1:0] coverage_value_o,
  output logic [PTR_BITS-1:0]     next_position_o
);

  localparam int unsigned STORE_DEPTH = CONTIGS * CONTIG_LENGTH;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_RUN   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  logic [COUNTER_BITS-1:0] store_q [STORE_DEPTH];
  logic [COUNTER_BITS-1:0] rd_data_q;

  state_e                  state_q, state_d;
  logic [ADDR_BITS-1:0]    clr_addr_q, clr_addr_d;
  logic [ADDR_BITS-1:0]    wr_addr_q, wr_addr_d;
  logic [PTR_BITS-1:0]     left_q, left_d;
  logic                    add_q, add_d;
  logic [COUNTER_BITS-1:0] val_q, val_d;
  logic [PTR_BITS-1:0]     pos_q, pos_d;
  logic                    out_valid_q, out_valid_d;
  logic [COUNTER_BITS-1:0] out_val_q;
  logic [PTR_BITS-1:0]     out_pos_q;

  logic                    out_free;
  logic                    mem_re, mem_we;
  logic [ADDR_BITS-1:0]    mem_ra, mem_wa;
  logic [COUNTER_BITS-1:0] mem_wd;
  logic [COUNTER_BITS-1:0] upd;

  assign out_free         = !out_valid_q || !out_stall_i;
  assign clearing_o       = (state_q == S_CLEAR);
  assign out_valid_o      = out_valid_q;
  assign coverage_value_o = out_val_q;
  assign next_position_o  = out_pos_q;

  // saturating step on the counter just read
  always_comb begin
    if (add_q) begin
      upd = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
    end else begin
      upd = (rd_data_q == '0) ? rd_data_q : rd_data_q - 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    wr_addr_d   = wr_addr_q;
    left_d      = left_q;
    add_d       = add_q;
    val_d       = val_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    mem_re      = 1'b0;
    mem_ra      = q_cmd_i.addr;
    mem_we      = 1'b0;
    mem_wa      = wr_addr_q;
    mem_wd      = upd;
    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_wa     = clr_addr_q;
        mem_wd     = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_BITS'(STORE_DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          pos_d   = q_cmd_i.next_pos;
          unique case (q_cmd_i.kind)
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = S_READ;
            end
            CMD_RUN: begin
              mem_re    = 1'b1;
              wr_addr_d = q_cmd_i.addr;
              left_d    = q_cmd_i.count - 1'b1;
              add_d     = q_cmd_i.add;
              state_d   = S_RUN;
            end
            default: begin
              val_d   = '0;
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_READ: begin
        val_d   = rd_data_q;
        state_d = S_OUT;
      end
      S_RUN: begin
        // write back this position, fetch the next one in the same cycle
        mem_we = 1'b1;
        if (left_q != '0) begin
          mem_re    = 1'b1;
          mem_ra    = wr_addr_q + 1'b1;
          wr_addr_d = wr_addr_q + 1'b1;
          left_d    = left_q - 1'b1;
        end else begin
          val_d   = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    left_q    <= left_d;
    add_q     <= add_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    if ((state_q == S_OUT) && out_free) begin
      out_val_q <= val_q;
      out_pos_q <= pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= store_q[mem_ra];
  end

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !q_pop_o)
    else $error("command popped during clearing pass");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && (left_q == '0) |=> (state_q == S_OUT))
    else $error("run did not finish after last position");
`endif

endmodule

### rtl/cigar_coverage_updater_top.sv
// Coverage pileup counter: one 16-bit counter per reference position for 4 contigs of
// 262144 positions. Each input word is either a counter read or one alignment operation;
// every word yields exactly one output word. After reset the block runs a clearing pass
// over the 1048576-entry counter memory, one entry per cycle, and holds in_stall_o high
// throughout that pass. Afterwards the front stage takes a word each cycle while its
// two-entry command queue has room; the walk pointer is updated there, so next_position
// is known at once. The back stage owns the counter memory (one write and one read port,
// registered read) and does one counter per cycle: a match or deletion passes idle, run
// (per position) and output; a read idle, read and output; a splice skip or ignored op
// idle and output. Unless output stalls, one read-modify-write per cycle sets the rate.
// Output words sit in a register, so the back stage moves on while a word waits.
module cigar_coverage_updater_top
  import ccu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic                    first_op_i,
  input  logic [CONTIG_BITS-1:0]  contig_i,
  input  logic [POS_BITS-1:0]     position_i,
  input  logic [1:0]              cigar_kind_i,
  input  logic [LEN_BITS-1:0]     run_length_i,
  input  logic                    add_mode_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [COUNTER_BITS-1:0] coverage_value_o,
  output logic [PTR_BITS-1:0]     next_position_o
);

  logic clearing;
  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, pop_cmd;

  // front: classify word, advance walk pointer, queue the command
  ccu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .first_op_i   (first_op_i),
    .contig_i     (contig_i),
    .position_i   (position_i),
    .cigar_kind_i (cigar_kind_i),
    .run_length_i (run_length_i),
    .add_mode_i   (add_mode_i),
    .clearing_i   (clearing),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  ccu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (q_empty)
  );

  // back: counter memory, clearing pass, result register
  ccu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_cmd_i          (pop_cmd),
    .q_pop_o          (q_pop),
    .clearing_o       (clearing),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .coverage_value_o (coverage_value_o),
    .next_position_o  (next_position_o)
  );

endmodule
